// ===== rtl/crb_pkg.sv =====
package crb_pkg;

   localparam int WORD_W = 64;
   localparam int TOL_W = 63;
   localparam int CSR_IDX_W = 2;
   localparam int DEF_STEP_LIMIT = 64;
   localparam int DEF_FRAC_BITS = 32;

   localparam logic [WORD_W-1:0] RST_COEF_SQUARE = 64'd8589934592;
   localparam logic [WORD_W-1:0] RST_COEF_LINEAR = 64'd12884901888;
   localparam logic [WORD_W-1:0] RST_COEF_CONSTANT = 64'd8589934592;
   localparam logic [TOL_W-1:0] RST_TOLERANCE = 63'd4295;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SQUARE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LINEAR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CONSTANT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 2'd3;

   // multiply sequence of one cubic evaluation
   localparam logic [1:0] OP_X2 = 2'd0;
   localparam logic [1:0] OP_X3 = 2'd1;
   localparam logic [1:0] OP_AX2 = 2'd2;
   localparam logic [1:0] OP_BX = 2'd3;

   typedef struct packed {
      logic done;
      logic sat;
      logic [WORD_W-1:0] value;
   } mul_rsp_type;

   // saturating signed add, returns {sat, sum}
   function automatic logic [WORD_W:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] s;
      logic ovf;
      s = a + b;
      ovf = (a[WORD_W-1] == b[WORD_W-1]) && (s[WORD_W-1] != a[WORD_W-1]);
      if (ovf) begin
         s = a[WORD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end
      return {ovf, s};
   endfunction

endpackage

// ===== rtl/crb_mul.sv =====
module crb_mul #(
   parameter int FRAC_BITS = crb_pkg::DEF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [crb_pkg::WORD_W-1:0] op_a,
   input  logic [crb_pkg::WORD_W-1:0] op_b,
   output crb_pkg::mul_rsp_type rsp
);

   localparam int W = crb_pkg::WORD_W;
   localparam int CNT_W = $clog2(W);

   typedef enum logic [3:0] {
      M_IDLE = 4'b0001,
      M_RUN  = 4'b0010,
      M_NEG  = 4'b0100,
      M_FIN  = 4'b1000
   } mul_state_type;

   mul_state_type st_ff, st_in;
   logic [W-1:0] ma_ff, ma_in;
   logic [W-1:0] hi_ff, hi_in;
   logic [W-1:0] lo_ff, lo_in;
   logic neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [W:0] sum;
   logic [2*W-1:0] prod;
   logic [2*W-1:0] shifted;
   logic [W:0] upper;
   logic ovf;

   always_comb begin
      st_in = st_ff;
      ma_in = ma_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, ma_ff} : {(W+1){1'b0}});
      prod = {hi_ff, lo_ff};
      case (st_ff)
         M_IDLE: begin
            if (start) begin
               ma_in = op_a[W-1] ? (~op_a + 1'b1) : op_a;
               lo_in = op_b[W-1] ? (~op_b + 1'b1) : op_b;
               hi_in = '0;
               neg_in = op_a[W-1] ^ op_b[W-1];
               cnt_in = '0;
               st_in = M_RUN;
            end
         end
         M_RUN: begin
            // one multiplier bit per cycle, shift-add
            hi_in = sum[W:1];
            lo_in = {sum[0], lo_ff[W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(W - 1)) begin
               st_in = M_NEG;
            end
         end
         M_NEG: begin
            if (neg_ff) begin
               {hi_in, lo_in} = ~prod + 1'b1;
            end
            st_in = M_FIN;
         end
         M_FIN: begin
            st_in = M_IDLE;
         end
         default: begin
            st_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= M_IDLE;
      end else begin
         st_ff <= st_in;
      end
      ma_ff <= ma_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign shifted = $signed(prod) >>> FRAC_BITS;
   assign upper = shifted[2*W-1:W-1];
   assign ovf = (upper != '0) && (upper != '1);

   always_comb begin
      rsp.done = (st_ff == M_FIN);
      rsp.sat = ovf;
      if (ovf) begin
         rsp.value = hi_ff[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         rsp.value = shifted[W-1:0];
      end
   end

endmodule

// ===== rtl/cubic_root_bisection_unit.sv =====
// One cubic evaluation is run per bisection step, plus one more for the first step,
// and each step also passes through the check and the decision states. An interval
// that stops at once goes from the check straight to the result word. One interval
// at a time; the next is taken the cycle after the result word is loaded. The shared
// bit-serial multiplier sets the step time. Synchronous active-high reset clears
// control and loads the register defaults.
module cubic_root_bisection_unit #(
   parameter int STEP_LIMIT = crb_pkg::DEF_STEP_LIMIT,
   parameter int FRAC_BITS = crb_pkg::DEF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [crb_pkg::WORD_W-1:0] req_low_end,
   input  logic [crb_pkg::WORD_W-1:0] req_high_end,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [crb_pkg::WORD_W-1:0] rsp_root,
   output logic rsp_saturated,
   output logic rsp_hit_limit,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [crb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [crb_pkg::WORD_W-1:0] csr_data
);

   localparam int W = crb_pkg::WORD_W;
   localparam int STEP_W = $clog2(STEP_LIMIT + 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_ISSUE  = 6'b000100,
      S_WAIT   = 6'b001000,
      S_DECIDE = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   logic [W-1:0] coef_sq_ff, coef_lin_ff, coef_c_ff;
   logic [crb_pkg::TOL_W-1:0] tol_ff;
   logic [W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [W-1:0] x_ff, x_in, x2_ff, x2_in, acc_ff, acc_in;
   logic [W-1:0] vlo_ff, vlo_in, vmid_ff, vmid_in;
   logic have_vlo_ff, have_vlo_in;
   logic [1:0] op_ff, op_in;
   logic sat_ff, sat_in, limit_ff, limit_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_root_ff, rsp_root_in;
   logic rsp_sat_ff, rsp_sat_in, rsp_limit_ff, rsp_limit_in;

   logic mul_start;
   logic [W-1:0] mul_a, mul_b;
   crb_pkg::mul_rsp_type mres;

   logic [W-1:0] width, mid_calc;
   logic [W:0] add1, add2;
   logic same_sign;

   crb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock),
      .reset(reset),
      .start(mul_start),
      .op_a(mul_a),
      .op_b(mul_b),
      .rsp(mres)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_sq_ff <= crb_pkg::RST_COEF_SQUARE;
         coef_lin_ff <= crb_pkg::RST_COEF_LINEAR;
         coef_c_ff <= crb_pkg::RST_COEF_CONSTANT;
         tol_ff <= crb_pkg::RST_TOLERANCE;
      end else if (csr_valid) begin
         case (csr_index)
            crb_pkg::CSR_COEF_SQUARE: coef_sq_ff <= csr_data;
            crb_pkg::CSR_COEF_LINEAR: coef_lin_ff <= csr_data;
            crb_pkg::CSR_COEF_CONSTANT: coef_c_ff <= csr_data;
            crb_pkg::CSR_TOLERANCE: tol_ff <= csr_data[crb_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = (st_ff != S_IDLE);
   assign mul_start = (st_ff == S_ISSUE);

   always_comb begin
      case (op_ff)
         crb_pkg::OP_X2: begin mul_a = x_ff; mul_b = x_ff; end
         crb_pkg::OP_X3: begin mul_a = x2_ff; mul_b = x_ff; end
         crb_pkg::OP_AX2: begin mul_a = coef_sq_ff; mul_b = x2_ff; end
         crb_pkg::OP_BX: begin mul_a = coef_lin_ff; mul_b = x_ff; end
         default: begin mul_a = x_ff; mul_b = x_ff; end
      endcase
   end

   assign width = hi_ff - lo_ff;
   assign mid_calc = lo_ff + {1'b0, width[W-1:1]};
   assign add1 = crb_pkg::sat_add(acc_ff, mres.value);
   assign add2 = crb_pkg::sat_add(add1[W-1:0], coef_c_ff);
   assign same_sign = ((!vlo_ff[W-1] && vlo_ff != '0) && (!vmid_ff[W-1] && vmid_ff != '0))
      || (vlo_ff[W-1] && vmid_ff[W-1]);

   always_comb begin
      st_in = st_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      x_in = x_ff;
      x2_in = x2_ff;
      acc_in = acc_ff;
      vlo_in = vlo_ff;
      vmid_in = vmid_ff;
      have_vlo_in = have_vlo_ff;
      op_in = op_ff;
      sat_in = sat_ff;
      limit_in = limit_ff;
      steps_in = steps_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_root_in = rsp_root_ff;
      rsp_sat_in = rsp_sat_ff;
      rsp_limit_in = rsp_limit_ff;
      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               lo_in = req_low_end;
               hi_in = req_high_end;
               sat_in = 1'b0;
               limit_in = 1'b0;
               steps_in = '0;
               have_vlo_in = 1'b0;
               st_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if ($signed(hi_ff) <= $signed(lo_ff)
                  || width <= {1'b0, tol_ff}) begin
               st_in = S_OUT;
            end else if (steps_ff >= STEP_W'(STEP_LIMIT)) begin
               limit_in = 1'b1;
               st_in = S_OUT;
            end else if (mid_calc == lo_ff) begin
               st_in = S_OUT;
            end else begin
               mid_in = mid_calc;
               x_in = have_vlo_ff ? mid_calc : lo_ff;
               op_in = crb_pkg::OP_X2;
               st_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            st_in = S_WAIT;
         end
         S_WAIT: begin
            if (mres.done) begin
               sat_in = sat_ff | mres.sat;
               op_in = op_ff + 1'b1;
               st_in = S_ISSUE;
               case (op_ff)
                  crb_pkg::OP_X2: x2_in = mres.value;
                  crb_pkg::OP_X3: acc_in = mres.value;
                  crb_pkg::OP_AX2: begin
                     acc_in = add1[W-1:0];
                     sat_in = sat_ff | mres.sat | add1[W];
                  end
                  crb_pkg::OP_BX: begin
                     sat_in = sat_ff | mres.sat | add1[W] | add2[W];
                     if (have_vlo_ff) begin
                        vmid_in = add2[W-1:0];
                        st_in = S_DECIDE;
                     end else begin
                        vlo_in = add2[W-1:0];
                        have_vlo_in = 1'b1;
                        x_in = mid_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DECIDE: begin
            // p(lo) of the next step is known from this one
            if (same_sign) begin
               lo_in = mid_ff;
               vlo_in = vmid_ff;
            end else begin
               hi_in = mid_ff;
            end
            steps_in = steps_ff + 1'b1;
            st_in = S_CHECK;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_root_in = lo_ff;
               rsp_sat_in = sat_ff;
               rsp_limit_in = limit_ff;
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      x_ff <= x_in;
      x2_ff <= x2_in;
      acc_ff <= acc_in;
      vlo_ff <= vlo_in;
      vmid_ff <= vmid_in;
      have_vlo_ff <= have_vlo_in;
      op_ff <= op_in;
      sat_ff <= sat_in;
      limit_ff <= limit_in;
      steps_ff <= steps_in;
      rsp_root_ff <= rsp_root_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_limit_ff <= rsp_limit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_root = rsp_root_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_hit_limit = rsp_limit_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("result word dropped while stalled");

   a_decide_order: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_DECIDE |=> $signed(lo_ff) < $signed(hi_ff))
      else $error("bisection step broke interval order");

   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      mres.done |-> st_ff == S_WAIT)
      else $error("multiplier finished outside wait state");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_CHECK |-> steps_ff <= STEP_W'(STEP_LIMIT))
      else $error("step count beyond limit");

endmodule
